FILE: rtl/core/mss_pkg.sv
package mss_pkg;

    localparam int ELEM_W    = 16;
    localparam int IDX_OUT_W = 8;
    localparam int SUM_OUT_W = 24;

    // input beat
    typedef struct packed {
        logic signed [ELEM_W-1:0] sample_value;
        logic                     end_of_array;
    } t_in;

    // result beat
    typedef struct packed {
        logic [IDX_OUT_W-1:0]        start_index;
        logic [IDX_OUT_W-1:0]        end_index;
        logic signed [SUM_OUT_W-1:0] best_sum;
    } t_out;

    // broadcast control for the cell row
    typedef struct packed {
        logic wr;     // write new data into the cell at the select index
        logic shift;  // cells below the select index take their right neighbor
    } t_cell_ctl;

endpackage

FILE: rtl/core/max_subarray_search.sv
// Loading: one beat per cycle, busy stays low while elements are taken.
// Search: after the beat flagged end_of_array, busy stays high while the runs
// of the n elements held are compared, one run per cycle at the head of the
// cell row; the result strobe comes in the last busy cycle.
// Reset (synchronous, active low) empties the store and returns to idle.
// The result is shown for one cycle only; the receiver cannot stall it.
module max_subarray_search #(
    parameter int DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  mss_pkg::t_in   i_data,
    output logic           busy,
    output logic           o_valid,
    output mss_pkg::t_out  o_result
);
    import mss_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ELEM_W + $clog2(DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DONE   = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_tail, n_tail;
    logic [IW-1:0]        r_pos, n_pos;
    logic [IW-1:0]        r_lm1, n_lm1;
    logic                 r_have, n_have;
    logic signed [SW-1:0] r_best, n_best;
    logic [IW-1:0]        r_bst, n_bst;
    logic [IW-1:0]        r_ben, n_ben;

    logic                 beat;
    logic                 not_full;
    t_cell_ctl            ctl;
    logic [IW-1:0]        sel;
    logic signed [SW-1:0] acc_new;
    logic signed [ELEM_W-1:0] elem_new;
    logic signed [SW-1:0] head_acc;
    logic signed [ELEM_W-1:0] head_elem;

    logic signed [SW-1:0]     acc_q   [DEPTH];
    logic signed [ELEM_W-1:0] elem_q  [DEPTH];
    logic signed [SW-1:0]     acc_nb  [DEPTH];
    logic signed [ELEM_W-1:0] elem_nb [DEPTH];

    assign busy      = (r_state != S_IDLE);
    assign beat      = start && !busy;
    assign not_full  = (r_count < CW'(DEPTH));
    assign head_acc  = acc_q[0];
    assign head_elem = elem_q[0];

    // cell row: run sums in one queue, pending elements in the other
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g < DEPTH - 1) begin : g_nb
            assign acc_nb[g]  = acc_q[g+1];
            assign elem_nb[g] = elem_q[g+1];
        end else begin : g_end
            assign acc_nb[g]  = '0;
            assign elem_nb[g] = '0;
        end
        mss_cell #(
            .IDX (g),
            .IW  (IW),
            .SW  (SW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_sel      (sel),
            .i_acc_new  (acc_new),
            .i_elem_new (elem_new),
            .i_acc_nb   (acc_nb[g]),
            .i_elem_nb  (elem_nb[g]),
            .o_acc      (acc_q[g]),
            .o_elem     (elem_q[g])
        );
    end

    // row control: loads write at the fill index, search rotates at the tail
    always_comb begin
        ctl      = '0;
        sel      = r_tail;
        acc_new  = head_acc + SW'(head_elem);
        elem_new = head_elem;
        if (r_state == S_SEARCH) begin
            ctl.wr    = 1'b1;
            ctl.shift = 1'b1;
        end else begin
            ctl.wr   = beat && not_full;
            sel      = r_count[IW-1:0];
            acc_new  = SW'(i_data.sample_value);
            elem_new = i_data.sample_value;
        end
    end

    // sequencer and best-run tracking
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_tail  = r_tail;
        n_pos   = r_pos;
        n_lm1   = r_lm1;
        n_have  = r_have;
        n_best  = r_best;
        n_bst   = r_bst;
        n_ben   = r_ben;
        case (r_state)
            S_IDLE: begin
                if (beat) begin
                    if (not_full) begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_data.end_of_array) begin
                        n_state = S_SEARCH;
                        n_tail  = not_full ? r_count[IW-1:0] : IW'(DEPTH - 1);
                        n_pos   = '0;
                        n_lm1   = '0;
                        n_have  = 1'b0;
                    end
                end
            end
            S_SEARCH: begin
                if (!r_have || head_acc > r_best) begin
                    n_have = 1'b1;
                    n_best = head_acc;
                    n_bst  = r_pos;
                    n_ben  = r_pos + r_lm1;
                end
                if (r_pos == r_tail) begin
                    if (r_tail == '0) begin
                        n_state = S_DONE;
                        n_count = '0;
                    end else begin
                        n_tail = r_tail - IW'(1);
                        n_lm1  = r_lm1 + IW'(1);
                        n_pos  = '0;
                    end
                end else begin
                    n_pos = r_pos + IW'(1);
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_have  <= n_have;
        end
        r_tail <= n_tail;
        r_pos  <= n_pos;
        r_lm1  <= n_lm1;
        r_best <= n_best;
        r_bst  <= n_bst;
        r_ben  <= n_ben;
    end

    // result formatting
    assign o_valid = (r_state == S_DONE);

    if (IW >= IDX_OUT_W) begin : g_idx_trunc
        assign o_result.start_index = r_bst[IDX_OUT_W-1:0];
        assign o_result.end_index   = r_ben[IDX_OUT_W-1:0];
    end else begin : g_idx_ext
        assign o_result.start_index = {{(IDX_OUT_W-IW){1'b0}}, r_bst};
        assign o_result.end_index   = {{(IDX_OUT_W-IW){1'b0}}, r_ben};
    end

    if (SW > SUM_OUT_W) begin : g_sum_sat
        localparam logic signed [SW-1:0] SMAX = SW'(signed'({1'b0, {(SUM_OUT_W-1){1'b1}}}));
        localparam logic signed [SW-1:0] SMIN = SW'(signed'({1'b1, {(SUM_OUT_W-1){1'b0}}}));
        always_comb begin
            if (r_best > SMAX) begin
                o_result.best_sum = SMAX[SUM_OUT_W-1:0];
            end else if (r_best < SMIN) begin
                o_result.best_sum = SMIN[SUM_OUT_W-1:0];
            end else begin
                o_result.best_sum = r_best[SUM_OUT_W-1:0];
            end
        end
    end else begin : g_sum_ext
        assign o_result.best_sum = SUM_OUT_W'(r_best);
    end

endmodule

FILE: rtl/core/mss_cell.sv
module mss_cell #(
    parameter int IDX = 0,
    parameter int IW  = 8,
    parameter int SW  = 24
) (
    input  logic                                i_clk,
    input  mss_pkg::t_cell_ctl                  i_ctl,
    input  logic [IW-1:0]                       i_sel,
    input  logic signed [SW-1:0]                i_acc_new,
    input  logic signed [mss_pkg::ELEM_W-1:0]   i_elem_new,
    input  logic signed [SW-1:0]                i_acc_nb,
    input  logic signed [mss_pkg::ELEM_W-1:0]   i_elem_nb,
    output logic signed [SW-1:0]                o_acc,
    output logic signed [mss_pkg::ELEM_W-1:0]   o_elem
);
    import mss_pkg::*;

    // run-sum queue slot sits at IDX, element queue slot is one behind
    localparam logic [IW:0] AIDX = (IW+1)'(IDX);
    localparam logic [IW:0] EIDX = (IW+1)'(IDX + 1);

    logic [IW:0]              sel_x;
    logic signed [SW-1:0]     r_acc, n_acc;
    logic signed [ELEM_W-1:0] r_elem, n_elem;

    assign sel_x = {1'b0, i_sel};

    // tail slot takes new data, slots ahead of it move one toward the head
    always_comb begin
        n_acc  = r_acc;
        n_elem = r_elem;
        if (i_ctl.wr && sel_x == AIDX) begin
            n_acc = i_acc_new;
        end else if (i_ctl.shift && AIDX < sel_x) begin
            n_acc = i_acc_nb;
        end
        if (i_ctl.wr && sel_x == EIDX) begin
            n_elem = i_elem_new;
        end else if (i_ctl.shift && EIDX < sel_x) begin
            n_elem = i_elem_nb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_elem <= n_elem;
    end

    assign o_acc  = r_acc;
    assign o_elem = r_elem;

endmodule

FILE: test/max_subarray_search_test.sv
module max_subarray_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mss_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam int ITEM_TARGET = 1950;
    localparam int STALL_LIMIT = 150000;
    localparam longint SUM_HI  = 64'sd8388607;
    localparam longint SUM_LO  = -64'sd8388608;

    typedef struct {
        t_in  beat;
        bit   typed;   // expected result given in the row
        t_out want;
    } t_row;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_in   i_data  = '0;
    logic  busy;
    logic  o_valid;
    t_out  o_result;

    // elements of the array being loaded, as the block should hold them
    logic signed [ELEM_W-1:0] held_elems [$];
    t_out pending_results [$];
    int   mismatches = 0;
    int   beats_sent = 0;
    int   gap_pct    = 13;
    int   stall_cnt  = 0;

    // directed rows: extremes, negatives, ties, full-length winner, bit toggles
    t_row dir_rows [22] = '{
        '{'{16'h7FFF, 1'b1}, 1'b1, '{8'd0, 8'd0, 24'h007FFF}},
        '{'{16'h8000, 1'b1}, 1'b1, '{8'd0, 8'd0, 24'hFF8000}},
        '{'{16'h0000, 1'b1}, 1'b1, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'hFFFF, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'hFFFF, 1'b1}, 1'b1, '{8'd0, 8'd0, 24'hFFFFFF}},
        '{'{16'h0005, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'hFFFD, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'h0007, 1'b1}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'h7FFF, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'h7FFF, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'h7FFF, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'h7FFF, 1'b1}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'h8000, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'h8000, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'h8000, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'h8000, 1'b1}, 1'b1, '{8'd0, 8'd0, 24'hFF8000}},
        '{'{16'h0003, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'hFFFD, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'h0003, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'hFFF6, 1'b1}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'h5555, 1'b0}, 1'b0, '{8'd0, 8'd0, 24'h000000}},
        '{'{16'hAAAA, 1'b1}, 1'b0, '{8'd0, 8'd0, 24'h000000}}
    };

    max_subarray_search #(
        .DEPTH (STORE_DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_data   (i_data),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // store one element and, on the last one, run the brute-force run search
    task automatic search_best_run(input t_in beat, output bit found, output t_out res);
        longint prefix [0:STORE_DEPTH];
        longint run_sum;
        longint best_sum;
        int     n;
        int     best_lo;
        int     best_hi;
        bit     have;
        found = 1'b0;
        res   = '0;
        if (held_elems.size() < STORE_DEPTH)
            held_elems.push_back(beat.sample_value);
        if (!beat.end_of_array)
            return;
        n        = held_elems.size();
        have     = 1'b0;
        best_sum = 0;
        best_lo  = 0;
        best_hi  = 0;
        prefix[0] = 0;
        for (int k = 0; k < n; k++)
            prefix[k + 1] = prefix[k] + longint'(held_elems[k]);
        // shorter runs first, earlier starts first, strictly greater wins
        for (int len = 1; len <= n; len++) begin
            for (int st = 0; st + len <= n; st++) begin
                run_sum = prefix[st + len] - prefix[st];
                if (!have || run_sum > best_sum) begin
                    have     = 1'b1;
                    best_sum = run_sum;
                    best_lo  = st;
                    best_hi  = st + len - 1;
                end
            end
        end
        if (best_sum > SUM_HI)
            best_sum = SUM_HI;
        if (best_sum < SUM_LO)
            best_sum = SUM_LO;
        res.start_index = IDX_OUT_W'(best_lo);
        res.end_index   = IDX_OUT_W'(best_hi);
        res.best_sum    = SUM_OUT_W'(best_sum);
        found = 1'b1;
        held_elems.delete();
    endtask

    // hand one beat to the block, then record what it should answer
    task automatic drive_beat(input t_in beat, input bit use_typed, input t_out typed_res);
        bit   found;
        t_out res;
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_data <= beat;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        beats_sent++;
        search_best_run(beat, found, res);
        if (found)
            pending_results.push_back(use_typed ? typed_res : res);
    endtask

    task automatic send_sample(input logic signed [ELEM_W-1:0] value, input bit last);
        t_in beat;
        beat.sample_value = value;
        beat.end_of_array = last;
        drive_beat(beat, 1'b0, '0);
    endtask

    // hold off until the block has answered everything
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_sample(input bit lean_negative);
        logic signed [ELEM_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2, 3:    v = ELEM_W'(int'($urandom_range(0, 40)) - 20);
            default: v = ELEM_W'($urandom);
        endcase
        if (lean_negative && v > 0 && $urandom_range(0, 3) != 0)
            v = -v;
        return v;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result start=%0d end=%0d sum=%0d", $time,
                         o_result.start_index, o_result.end_index,
                         $signed(o_result.best_sum));
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.start_index !== want.start_index) begin
                    $display("%0t: start_index expected %0d actual %0d", $time,
                             want.start_index, o_result.start_index);
                    mismatches++;
                end
                if (o_result.end_index !== want.end_index) begin
                    $display("%0t: end_index expected %0d actual %0d", $time,
                             want.end_index, o_result.end_index);
                    mismatches++;
                end
                if (o_result.best_sum !== want.best_sum) begin
                    $display("%0t: best_sum expected %0d actual %0d", $time,
                             $signed(want.best_sum), $signed(o_result.best_sum));
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles in which no beat moves either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt == STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int  arr_len;
        int  pick;
        int  array_no;
        bit  lean_neg;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (dir_rows[r])
            drive_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want);
        drain_results();

        // full store: largest positive sum over exactly DEPTH elements
        for (int k = 0; k < STORE_DEPTH; k++)
            send_sample(16'h7FFF, k == STORE_DEPTH - 1);
        // full store, then dropped elements, the last one dropped too
        for (int k = 0; k < STORE_DEPTH + 4; k++)
            send_sample(pick_sample(1'b0), k == STORE_DEPTH + 3);
        // all minimum values, one dropped closing element
        for (int k = 0; k < STORE_DEPTH + 1; k++)
            send_sample(16'h8000, k == STORE_DEPTH);
        drain_results();

        // random arrays, mostly short
        array_no = 0;
        while (beats_sent < ITEM_TARGET) begin
            gap_pct = (array_no >= 30 && array_no < 60) ? 0 : 13;
            pick = $urandom_range(0, 99);
            if (pick < 80)
                arr_len = $urandom_range(1, 12);
            else if (pick < 95)
                arr_len = $urandom_range(13, 40);
            else
                arr_len = $urandom_range(41, 90);
            lean_neg = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < arr_len; k++)
                send_sample(pick_sample(lean_neg), k == arr_len - 1);
            array_no++;
            if (array_no % 25 == 0)
                drain_results();
        end

        // wind down
        drain_results();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
